// ----- src/lfc_pkg.sv -----
package lfc_pkg;

  // frame layout and length checks
  localparam logic [17:0] CTL_MIN_BYTES = 18'd9;
  localparam logic [17:0] GEN_MIN_BYTES = 18'd13;
  localparam logic [17:0] CTL_OVERHEAD  = 18'd10;
  localparam logic [17:0] GEN_OVERHEAD  = 18'd14;
  localparam logic [16:0] CTL_HDR_BYTES = 17'd8;
  localparam logic [16:0] GEN_HDR_BYTES = 17'd12;
  localparam logic [16:0] COUNT_MAX     = 17'h1FFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  // configuration register indexes
  localparam logic [1:0] REG_CONTROL_TYPE_MAP    = 2'd0;
  localparam logic [1:0] REG_MAX_CONTROL_PAYLOAD = 2'd1;
  localparam logic [1:0] REG_MAX_GENERIC_PAYLOAD = 2'd2;

  localparam logic [15:0] MAX_CONTROL_RESET = 16'd64;
  localparam logic [15:0] MAX_GENERIC_RESET = 16'd256;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_SIZE     = 2'd1,
    STATUS_LEN_MISMATCH = 2'd2,
    STATUS_CRC_MISMATCH = 2'd3
  } lfc_status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } lfc_kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } lfc_item_t;

  typedef struct packed {
    logic [15:0] control_type_map;
    logic [15:0] max_control_payload;
    logic [15:0] max_generic_payload;
  } lfc_cfg_t;

  typedef struct packed {
    lfc_kind_e   kind;
    logic [7:0]  payload_byte;
    lfc_status_e status;
    logic [7:0]  preamble;
    logic [7:0]  src_board;
    logic [7:0]  dst_board;
    logic [15:0] seq_num;
    logic [7:0]  type_code;
    logic [15:0] frag_total;
    logic [15:0] frag_index;
    logic [15:0] payload_len;
  } lfc_result_t;

  // msb-first crc-16, poly 0x1021, one byte per call
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- src/link_frame_checker_crc16.sv -----
// crc-16 framed packet checker: takes a received frame one byte word per cycle on the
// slave stream (tlast marks the last byte of the buffer), latches the header (preamble,
// sender, receiver, little-endian sequence, type/flag, and for generic types fragment
// count and number), then the payload length; payload bytes come out as kind-0 words
// and the last byte yields one kind-1 status word (ok, bad size, length mismatch, crc
// mismatch) carrying the header. crc-16 is poly 0x1021, init 0, over header and payload.
// the block takes one byte every cycle unless the result stream stalls; a word is held
// in the input register, then header decode and the byte-wide crc update run into the
// result register. configuration is written through cfg_we_i; the user must do so while
// no frame is in flight, as the block does not enforce it.
module link_frame_checker_crc16
  import lfc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  // receive byte stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  input  logic         s_axis_tlast,   // frame_end
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] payload_byte, [9:8] status, [17:10] preamble, [25:18] src_board,
  // [33:26] dst_board, [49:34] seq_num, [57:50] type_code, [73:58] frag_total,
  // [89:74] frag_index, [105:90] payload_len, [111:106] zero
  output logic [111:0] m_axis_tdata,
  output logic [0:0]   m_axis_tuser    // [0] kind
);

  lfc_cfg_t    cfg_q;
  logic        item_valid;
  lfc_item_t   item;
  logic        advance;
  logic        res_valid;
  lfc_result_t res;
  logic        out_valid_q, out_valid_d;
  lfc_result_t out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_type_map    <= '0;
      cfg_q.max_control_payload <= MAX_CONTROL_RESET;
      cfg_q.max_generic_payload <= MAX_GENERIC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CONTROL_TYPE_MAP:    cfg_q.control_type_map    <= cfg_data_i;
        REG_MAX_CONTROL_PAYLOAD: cfg_q.max_control_payload <= cfg_data_i;
        REG_MAX_GENERIC_PAYLOAD: cfg_q.max_generic_payload <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the buffered byte moves on when the result register is free or draining
  assign advance = item_valid && (!out_valid_q || m_axis_tready);

  lfc_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .advance_i     (advance),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  lfc_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (advance && res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {6'b000000, out_q.payload_len, out_q.frag_index, out_q.frag_total,
                          out_q.type_code, out_q.seq_num, out_q.dst_board,
                          out_q.src_board, out_q.preamble, out_q.status,
                          out_q.payload_byte};

endmodule

// ----- src/lfc_in_stage.sv -----
module lfc_in_stage
  import lfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic      s_axis_tlast,
  input  logic      advance_i,
  output logic      item_valid_o,
  output lfc_item_t item_o
);

  logic      valid_q, valid_d;
  lfc_item_t item_q;

  assign s_axis_tready = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (s_axis_tready) begin
      valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.rx_byte   <= s_axis_tdata;
      item_q.frame_end <= s_axis_tlast;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- src/lfc_parse.sv -----
module lfc_parse
  import lfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  lfc_item_t   item_i,
  input  lfc_cfg_t    cfg_i,
  output logic        res_valid_o,
  output lfc_result_t res_o
);

  logic [16:0] count_q, count_d;
  logic [7:0]  preamble_q, preamble_d;
  logic [7:0]  sender_q, sender_d;
  logic [7:0]  receiver_q, receiver_d;
  logic [15:0] seq_q, seq_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] total_q, total_d;
  logic [15:0] frag_q, frag_d;
  logic [15:0] len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rcv_q, rcv_d;

  logic        ctl;
  logic [7:0]  b;
  logic [16:0] hdr_bytes;
  logic [16:0] body_end;
  logic [17:0] n;
  logic [17:0] len_w;
  lfc_status_e status;

  always_comb begin
    b          = item_i.rx_byte;
    preamble_d = preamble_q;
    sender_d   = sender_q;
    receiver_d = receiver_q;
    seq_d      = seq_q;
    type_d     = type_q;
    total_d    = total_q;
    frag_d     = frag_q;
    len_d      = len_q;
    crc_d      = crc_q;
    rcv_d      = rcv_q;

    case (count_q)
      17'd0:   preamble_d = b;
      17'd1:   sender_d   = b;
      17'd2:   receiver_d = b;
      17'd3:   seq_d      = {seq_q[15:8], b};
      17'd4:   seq_d      = {b, seq_q[7:0]};
      17'd5:   type_d     = b;
      default: ;
    endcase

    // frame kind follows the type nibble and the live map
    ctl = cfg_i.control_type_map[type_d[7:4]];

    if (ctl) begin
      case (count_q)
        17'd6:   len_d = {len_q[15:8], b};
        17'd7:   len_d = {b, len_q[7:0]};
        default: ;
      endcase
    end else begin
      case (count_q)
        17'd6:   total_d = {total_q[15:8], b};
        17'd7:   total_d = {b, total_q[7:0]};
        17'd8:   frag_d  = {frag_q[15:8], b};
        17'd9:   frag_d  = {b, frag_q[7:0]};
        17'd10:  len_d   = {len_q[15:8], b};
        17'd11:  len_d   = {b, len_q[7:0]};
        default: ;
      endcase
    end

    hdr_bytes = ctl ? CTL_HDR_BYTES : GEN_HDR_BYTES;
    body_end  = hdr_bytes + {1'b0, len_d};

    if (count_q < body_end) begin
      crc_d = crc16_byte(crc_q, b);
    end else if (count_q == body_end) begin
      rcv_d = {rcv_q[15:8], b};
    end else if (count_q == body_end + 17'd1) begin
      rcv_d = {b, rcv_q[7:0]};
    end

    n     = {1'b0, count_q} + 18'd1;
    len_w = {2'b00, len_d};

    if (ctl) begin
      if (n < CTL_MIN_BYTES) begin
        status = STATUS_BAD_SIZE;
      end else if (len_w > n) begin
        status = STATUS_LEN_MISMATCH;
      end else if (len_d == 16'd0) begin
        status = STATUS_BAD_SIZE;
      end else if (len_d > cfg_i.max_control_payload || CTL_OVERHEAD + len_w > n) begin
        status = STATUS_BAD_SIZE;
      end else if (rcv_d != crc_d) begin
        status = STATUS_CRC_MISMATCH;
      end else begin
        status = STATUS_OK;
      end
    end else begin
      if (n < GEN_MIN_BYTES) begin
        status = STATUS_BAD_SIZE;
      end else if ((len_d > cfg_i.max_generic_payload && total_d != 16'd1) ||
                   GEN_OVERHEAD + len_w > n) begin
        status = STATUS_BAD_SIZE;
      end else if (total_d != 16'd1 && rcv_d != crc_d) begin
        status = STATUS_CRC_MISMATCH;
      end else begin
        status = STATUS_OK;
      end
    end

    res_o.preamble     = preamble_d;
    res_o.src_board    = sender_d;
    res_o.dst_board    = receiver_d;
    res_o.seq_num      = seq_d;
    res_o.type_code    = type_d;
    res_o.frag_total   = total_d;
    res_o.frag_index   = frag_d;
    res_o.payload_len  = len_d;
    if (item_i.frame_end) begin
      res_valid_o        = 1'b1;
      res_o.kind         = KIND_STATUS;
      res_o.payload_byte = 8'h00;
      res_o.status       = status;
    end else begin
      res_valid_o        = (count_q >= hdr_bytes) && (count_q < body_end);
      res_o.kind         = KIND_PAYLOAD;
      res_o.payload_byte = b;
      res_o.status       = STATUS_OK;
    end

    count_d = (count_q < COUNT_MAX) ? count_q + 17'd1 : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      preamble_q <= '0;
      sender_q   <= '0;
      receiver_q <= '0;
      seq_q      <= '0;
      type_q     <= '0;
      total_q    <= '0;
      frag_q     <= '0;
      len_q      <= '0;
      crc_q      <= '0;
      rcv_q      <= '0;
    end else if (advance_i) begin
      if (item_i.frame_end) begin
        count_q    <= '0;
        preamble_q <= '0;
        sender_q   <= '0;
        receiver_q <= '0;
        seq_q      <= '0;
        type_q     <= '0;
        total_q    <= '0;
        frag_q     <= '0;
        len_q      <= '0;
        crc_q      <= '0;
        rcv_q      <= '0;
      end else begin
        count_q    <= count_d;
        preamble_q <= preamble_d;
        sender_q   <= sender_d;
        receiver_q <= receiver_d;
        seq_q      <= seq_d;
        type_q     <= type_d;
        total_q    <= total_d;
        frag_q     <= frag_d;
        len_q      <= len_d;
        crc_q      <= crc_d;
        rcv_q      <= rcv_d;
      end
    end
  end

endmodule
